// ----- rtl/adsr_pkg.sv -----
// adsr_pkg: shared widths, field codes and phase codes for the linear adsr envelope unit
// used by adsr_mul, adsr_div and linear_adsr_envelope_unit; no dependencies
package adsr_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
  localparam int SAMPLE_BITS    = 24;
  localparam int ELAPSED_BITS   = COUNT_BITS + 1;
  localparam int MUL_A_BITS     = ELAPSED_BITS + GAIN_BITS;
  localparam int NUM_BITS       = COUNT_BITS + GAIN_BITS;
  localparam int QUOT_BITS      = GAIN_BITS;
  localparam int STEP_CNT_BITS  = $clog2(GAIN_BITS);

  localparam logic [GAIN_BITS-1:0]    UNITY       = GAIN_BITS'(1) << GAIN_FRAC_BITS;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  // request kinds carried on tuser
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

  // envelope phase codes as reported on the output
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

endpackage

// ----- rtl/adsr_mul.sv -----
// adsr_mul: bit-serial shift-and-add multiplier, one multiplier bit per cycle
// signed multiplicand, unsigned gain-width multiplier; depends on adsr_pkg
module adsr_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [adsr_pkg::MUL_A_BITS-1:0] mcand_in,
  input  logic        [adsr_pkg::GAIN_BITS-1:0]  mplier_in,
  output logic                                 done,
  output logic signed [adsr_pkg::MUL_A_BITS-1:0] prod
);
  import adsr_pkg::*;

  logic signed [MUL_A_BITS-1:0] mcand;
  logic        [GAIN_BITS-1:0]  mplier;
  logic        [STEP_CNT_BITS-1:0] cnt;
  logic                         busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_BITS'(GAIN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= mcand_in;
      mplier <= mplier_in;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ----- rtl/adsr_div.sv -----
// adsr_div: restoring divider, one quotient bit per cycle, gain-width quotient
// caller guarantees the quotient fits and the divisor is nonzero; depends on adsr_pkg
module adsr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [adsr_pkg::NUM_BITS-1:0]   num_in,
  input  logic [adsr_pkg::COUNT_BITS-1:0] den_in,
  output logic                            done,
  output logic [adsr_pkg::QUOT_BITS-1:0]  quot
);
  import adsr_pkg::*;

  logic [COUNT_BITS:0]    rem;
  logic [QUOT_BITS-1:0]   nlow;
  logic [COUNT_BITS-1:0]  den;
  logic [STEP_CNT_BITS-1:0] cnt;
  logic                   busy;
  logic [COUNT_BITS+1:0]  shifted;
  logic [COUNT_BITS+1:0]  diff;

  assign shifted = {rem, nlow[QUOT_BITS-1]};
  assign diff    = shifted - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_BITS'(QUOT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so the top bit of shifted is zero
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num_in[NUM_BITS-1:QUOT_BITS]};
      nlow <= num_in[QUOT_BITS-1:0];
      den  <= den_in;
      quot <= '0;
    end else if (busy) begin
      rem  <= diff[COUNT_BITS+1] ? shifted[COUNT_BITS:0] : diff[COUNT_BITS:0];
      quot <= {quot[QUOT_BITS-2:0], ~diff[COUNT_BITS+1]};
      nlow <= nlow << 1;
    end
  end

endmodule

// ----- rtl/linear_adsr_envelope_unit.sv -----
// linear_adsr_envelope_unit: one-voice linear adsr envelope, scales the mixed sample
// depends on adsr_pkg, adsr_mul (serial multiplier) and adsr_div (serial divider)

// One request is taken at a time. A note-on, note-off or unused kind goes straight to the
// done state and returns its result once the output register is free. A tick first runs
// sample times gain through the bit-serial multiplier, which is all that a tick that only
// holds or changes phase needs; an attack ramp step adds one pass of the bit-serial divider,
// and a decay or release ramp step adds a second multiplier pass before the divide. Those
// serial units set the rate. The next request is taken as soon as the result sits in the
// output register, even if it has not been taken yet.
// Configuration writes are always ready and must only be made while no request is in work.
module linear_adsr_envelope_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] mix_sample
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] out_sample, [39:24] env_gain, [42:40] env_phase
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import adsr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MULO = 5'b00010,
    ST_MULN = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [COUNT_BITS-1:0]   attack_len, decay_len, release_len;
  logic [GAIN_BITS-1:0]    sustain_level;
  logic [2:0]              phase;
  logic [ELAPSED_BITS-1:0] elapsed, release_elapsed;
  logic [GAIN_BITS-1:0]    cur_gain, held_gain;

  // pending ramp job for the current tick
  logic                    need_mul, need_div, ramp_sub;
  logic [GAIN_BITS-1:0]    ramp_base;
  logic [ELAPSED_BITS-1:0] num_a;
  logic [GAIN_BITS-1:0]    num_b;
  logic [COUNT_BITS-1:0]   div_den;
  logic [SAMPLE_BITS-1:0]  res_sample;

  logic [SAMPLE_BITS-1:0]  out_sample;
  logic [GAIN_BITS-1:0]    out_gain;
  logic [2:0]              out_phase;

  logic in_acc, out_free;
  logic [1:0] func;
  logic signed [SAMPLE_BITS-1:0] mix_sample;

  // next-step decisions for a tick
  logic [ELAPSED_BITS-1:0] e_inc, r_inc, off;
  logic [GAIN_BITS-1:0]    sus;
  logic [2:0]              tick_phase;
  logic [GAIN_BITS-1:0]    tick_gain, tick_base, tick_b;
  logic                    tick_mul, tick_div, tick_sub;
  logic [ELAPSED_BITS-1:0] tick_a;
  logic [COUNT_BITS-1:0]   tick_den;

  logic                          mul_start, mul_done, div_start, div_done;
  logic signed [MUL_A_BITS-1:0]  mul_a, mul_prod;
  logic        [GAIN_BITS-1:0]   mul_b;
  logic        [NUM_BITS-1:0]    div_num;
  logic        [QUOT_BITS-1:0]   div_quot;

  assign func       = s_tuser;
  assign mix_sample = s_tdata[SAMPLE_BITS-1:0];
  assign s_tready   = (state == ST_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = 1'b1;
  assign m_tdata    = {5'b0, out_phase, out_gain, out_sample};

  always_comb begin
    e_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
    r_inc = (release_elapsed == ELAPSED_MAX) ? release_elapsed : release_elapsed + 1'b1;
    sus   = (sustain_level > UNITY) ? UNITY : sustain_level;
    off   = (e_inc > {1'b0, attack_len}) ? e_inc - {1'b0, attack_len} : '0;
    tick_phase = phase;
    tick_gain  = cur_gain;
    tick_mul   = 1'b0;
    tick_div   = 1'b0;
    tick_sub   = 1'b0;
    tick_base  = cur_gain;
    tick_a     = e_inc;
    tick_b     = cur_gain;
    tick_den   = attack_len;
    case (phase)
      PH_ATTACK: begin
        if (e_inc > {1'b0, attack_len}) begin
          tick_phase = PH_DECAY;
          tick_gain  = UNITY;
        end else begin
          tick_div = 1'b1;
        end
      end
      PH_DECAY: begin
        if (decay_len == '0 || off > {1'b0, decay_len}) begin
          tick_phase = PH_SUSTAIN;
          tick_gain  = sus;
        end else begin
          tick_mul  = 1'b1;
          tick_div  = 1'b1;
          tick_sub  = 1'b1;
          tick_base = UNITY;
          tick_a    = off;
          tick_b    = UNITY - sus;
          tick_den  = decay_len;
        end
      end
      PH_RELEASE: begin
        if (r_inc >= {1'b0, release_len}) begin
          tick_phase = PH_IDLE;
          tick_gain  = '0;
        end else begin
          tick_mul  = 1'b1;
          tick_div  = 1'b1;
          tick_sub  = 1'b1;
          tick_base = held_gain;
          tick_a    = r_inc;
          tick_b    = held_gain;
          tick_den  = release_len;
        end
      end
      default: ;
    endcase
  end

  // the multiplier serves the output product first, then the ramp numerator
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = MUL_A_BITS'(mix_sample);
    mul_b     = cur_gain;
    div_num   = NUM_BITS'({num_a, {GAIN_FRAC_BITS{1'b0}}});
    unique case (state)
      ST_IDLE: begin
        mul_start = in_acc && (func == FUNC_TICK);
      end
      ST_MULO: begin
        mul_a     = MUL_A_BITS'($signed({1'b0, num_a}));
        mul_b     = num_b;
        mul_start = mul_done && need_mul;
        div_start = mul_done && !need_mul && need_div;
      end
      ST_MULN: begin
        div_num   = mul_prod[NUM_BITS-1:0];
        div_start = mul_done;
      end
      default: ;
    endcase
  end

  adsr_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .mcand_in (mul_a),
    .mplier_in(mul_b),
    .done     (mul_done),
    .prod     (mul_prod)
  );

  adsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_in(div_num),
    .den_in(div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      attack_len      <= COUNT_BITS'(480);
      decay_len       <= COUNT_BITS'(4800);
      sustain_level   <= GAIN_BITS'(16384);
      release_len     <= COUNT_BITS'(4800);
      phase           <= PH_IDLE;
      elapsed         <= '0;
      release_elapsed <= '0;
      cur_gain        <= '0;
      held_gain       <= '0;
      need_mul        <= 1'b0;
      need_div        <= 1'b0;
      ramp_sub        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ATTACK:  attack_len    <= cfg_data;
          REG_DECAY:   decay_len     <= cfg_data;
          REG_SUSTAIN: sustain_level <= cfg_data[GAIN_BITS-1:0];
          REG_RELEASE: release_len   <= cfg_data;
          default: ;
        endcase
      end

      // a finished result reloads valid below in the same cycle
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (func == FUNC_TICK) begin
              phase    <= tick_phase;
              cur_gain <= tick_gain;
              need_mul <= tick_mul;
              need_div <= tick_div;
              ramp_sub <= tick_sub;
              if (phase == PH_ATTACK || phase == PH_DECAY) begin
                elapsed <= e_inc;
              end
              if (phase == PH_RELEASE) begin
                release_elapsed <= r_inc;
              end
              state <= ST_MULO;
            end else begin
              if (func == FUNC_NOTE_ON) begin
                phase           <= PH_ATTACK;
                elapsed         <= '0;
                release_elapsed <= '0;
                cur_gain        <= '0;
                held_gain       <= '0;
              end else if (func == FUNC_NOTE_OFF &&
                           phase inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN}) begin
                held_gain       <= cur_gain;
                release_elapsed <= '0;
                if (release_len == '0) begin
                  phase    <= PH_IDLE;
                  cur_gain <= '0;
                end else begin
                  phase <= PH_RELEASE;
                end
              end
              state <= ST_DONE;
            end
          end
        end
        ST_MULO: begin
          if (mul_done) begin
            if (need_mul) begin
              state <= ST_MULN;
            end else if (need_div) begin
              state <= ST_DIV;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MULN: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cur_gain <= ramp_sub ? ramp_base - div_quot : div_quot;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_sample <= '0;
      ramp_base  <= tick_base;
      num_a      <= tick_a;
      num_b      <= tick_b;
      div_den    <= tick_den;
    end
    if (state == ST_MULO && mul_done) begin
      // floor of the product by the gain scale
      res_sample <= mul_prod[GAIN_FRAC_BITS +: SAMPLE_BITS];
    end
    if (state == ST_DONE && out_free) begin
      out_sample <= res_sample;
      out_gain   <= cur_gain;
      out_phase  <= phase;
    end
  end

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (cur_gain == '0))
    else $error("idle phase with nonzero gain");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:24] <= UNITY))
    else $error("reported gain above unity");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_den != '0))
    else $error("ramp divide with zero length");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished result not presented");

endmodule

// ----- tb/sv/adsr_envelope_checker.sv -----
// adsr_envelope_checker: watches the request, result and register channels of the envelope
// unit, keeps its own envelope state and compares every result field by field; uses adsr_pkg
module adsr_envelope_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] mix_sample
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [23:0] out_sample, [39:24] env_gain, [42:40] env_phase
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          outstanding,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  localparam int DUE_DEPTH = 64;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] out_sample;
    logic [GAIN_BITS-1:0]   gain;
    logic [2:0]             phase;
  } env_result_t;

  // ring of predicted results waiting for the unit
  env_result_t due_results [DUE_DEPTH];
  int          due_wr = 0;
  int          due_rd = 0;

  logic [COUNT_BITS-1:0]   attack_len, decay_len, release_len;
  logic [15:0]             sustain_level;
  logic [2:0]              phase;
  logic [ELAPSED_BITS-1:0] elapsed, rel_elapsed;
  logic [GAIN_BITS-1:0]    gain, held_gain;
  int                      errors = 0;

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  function automatic logic [ELAPSED_BITS-1:0] count_up_sat(logic [ELAPSED_BITS-1:0] v);
    return (v == ELAPSED_MAX) ? v : v + 1'b1;
  endfunction

  // applies one request to the envelope copy and returns the result it should produce
  function automatic env_result_t predict_envelope(logic [1:0] kind, logic [23:0] raw);
    env_result_t      r;
    logic signed [63:0] prod;
    logic [63:0]        sus, off;
    r = '0;
    case (kind)
      FUNC_TICK: begin
        // scaled by the gain before this tick's update, floored
        prod = 64'($signed(raw)) * $signed(64'(gain));
        r.out_sample = 24'(prod >>> GAIN_FRAC_BITS);
        case (phase)
          PH_ATTACK: begin
            elapsed = count_up_sat(elapsed);
            if (elapsed > attack_len) begin
              phase = PH_DECAY;
              gain  = UNITY;
            end else begin
              gain = GAIN_BITS'(64'(elapsed) * 64'(UNITY) / 64'(attack_len));
            end
          end
          PH_DECAY: begin
            sus = (sustain_level > UNITY) ? 64'(UNITY) : 64'(sustain_level);
            elapsed = count_up_sat(elapsed);
            off = (elapsed > attack_len) ? 64'(elapsed) - 64'(attack_len) : 64'd0;
            if (decay_len == '0 || off > 64'(decay_len)) begin
              phase = PH_SUSTAIN;
              gain  = GAIN_BITS'(sus);
            end else begin
              gain = GAIN_BITS'(64'(UNITY) - (64'(UNITY) - sus) * off / 64'(decay_len));
            end
          end
          PH_RELEASE: begin
            rel_elapsed = count_up_sat(rel_elapsed);
            if (rel_elapsed >= release_len) begin
              phase = PH_IDLE;
              gain  = '0;
            end else begin
              gain = GAIN_BITS'(64'(held_gain)
                                - 64'(held_gain) * 64'(rel_elapsed) / 64'(release_len));
            end
          end
          default: ;
        endcase
      end
      FUNC_NOTE_ON: begin
        phase       = PH_ATTACK;
        elapsed     = '0;
        rel_elapsed = '0;
        gain        = '0;
        held_gain   = '0;
      end
      FUNC_NOTE_OFF: begin
        if (phase == PH_ATTACK || phase == PH_DECAY || phase == PH_SUSTAIN) begin
          held_gain   = gain;
          rel_elapsed = '0;
          if (release_len == '0) begin
            phase = PH_IDLE;
            gain  = '0;
          end else begin
            phase = PH_RELEASE;
          end
        end
      end
      default: ;
    endcase
    r.gain  = gain;
    r.phase = phase;
    return r;
  endfunction

  always @(posedge clk) begin
    env_result_t want;
    if (rst) begin
      // register reset values of the unit
      attack_len    = 24'd480;
      decay_len     = 24'd4800;
      sustain_level = 16'd16384;
      release_len   = 24'd4800;
      phase         = PH_IDLE;
      elapsed       = '0;
      rel_elapsed   = '0;
      gain          = '0;
      held_gain     = '0;
      due_wr        = 0;
      due_rd        = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:  attack_len    = cfg_data;
          REG_DECAY:   decay_len     = cfg_data;
          REG_SUSTAIN: sustain_level = cfg_data[15:0];
          REG_RELEASE: release_len   = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (due_wr == due_rd) begin
          flag_mismatch($sformatf("result %h with no request pending", m_tdata));
        end else begin
          want = due_results[due_rd % DUE_DEPTH];
          due_rd++;
          if (m_tdata[23:0] !== want.out_sample)
            flag_mismatch($sformatf("out_sample got %0d want %0d",
                                    $signed(m_tdata[23:0]), $signed(want.out_sample)));
          if (m_tdata[39:24] !== want.gain)
            flag_mismatch($sformatf("env_gain got %0d want %0d", m_tdata[39:24], want.gain));
          if (m_tdata[42:40] !== want.phase)
            flag_mismatch($sformatf("env_phase got %0d want %0d", m_tdata[42:40], want.phase));
        end
      end
      if (s_tvalid && s_tready) begin
        due_results[due_wr % DUE_DEPTH] = predict_envelope(s_tuser, s_tdata);
        due_wr++;
      end
    end
    outstanding <= due_wr - due_rd;
    fail_count  <= errors;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: clock, reset, request and register stimulus for linear_adsr_envelope_unit
// depends on adsr_pkg, the unit and adsr_envelope_checker, which predicts and compares
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RUN_ITEMS   = 740;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ATTACK;
  logic [23:0] cfg_data = '0;

  int outstanding;
  int fail_count;
  bit steady = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int sent = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  linear_adsr_envelope_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  adsr_envelope_checker env_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  // valid stays high between back-to-back requests, it only drops for a gap
  task automatic send_request(input logic [1:0] kind, input logic [23:0] smp);
    while (!steady && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= smp;
    sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic [23:0] atk, dec, sus, rel);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_DECAY, dec);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, rel);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'hFFFFFF;
      3: return 24'($urandom_range(0, 31));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] pick_len();
    case ($urandom_range(0, 19)) inside
      [0:1]: return '0;
      2: return 24'hFFFFFF;
      3: return 24'($urandom());
      4: return 24'd1;
      default: return 24'($urandom_range(2, 12));
    endcase
  endfunction

  // upper byte is outside the 16-bit register and should be dropped
  function automatic logic [23:0] pick_level();
    logic [15:0] lvl;
    case ($urandom_range(0, 9))
      0: lvl = '0;
      1: lvl = UNITY;
      2: lvl = 16'hFFFF;
      3: lvl = 16'($urandom());
      default: lvl = 16'($urandom_range(0, 32768));
    endcase
    return {8'($urandom()), lvl};
  endfunction

  // mostly the intended request, sometimes a random one in its place
  task automatic send_shaped(input logic [1:0] kind);
    if ($urandom_range(0, 99) < 12) send_request(2'($urandom_range(0, 3)), pick_sample());
    else send_request(kind, pick_sample());
  endtask

  task automatic play_phrase();
    int held_ticks;
    int tail_ticks;
    held_ticks = $urandom_range(0, 24);
    tail_ticks = $urandom_range(0, 16);
    send_shaped(FUNC_NOTE_ON);
    repeat (held_ticks) send_shaped(FUNC_TICK);
    if ($urandom_range(0, 4) != 0) send_shaped(FUNC_NOTE_OFF);
    repeat (tail_ticks) send_shaped(FUNC_TICK);
  endtask

  initial begin
    int phase_no;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a tick and ignored requests while idle, then a note starts
    send_request(FUNC_TICK, 24'h7FFFFF);
    send_request(FUNC_NOTE_OFF, 24'h800000);
    send_request(FUNC_UNUSED, 24'hFFFFFF);
    send_request(FUNC_NOTE_ON, 24'h555555);

    // no attack, no decay, sustain above unity, no release
    drain();
    write_regs(24'h000000, 24'h000000, 24'hABFFFF, 24'h000000);
    send_request(FUNC_TICK, 24'h800000);
    send_request(FUNC_TICK, 24'h800000);
    send_request(FUNC_TICK, 24'h7FFFFF);
    send_request(FUNC_TICK, 24'hFFFFFF);
    send_request(FUNC_NOTE_OFF, 24'h000000);
    send_request(FUNC_NOTE_ON, 24'h000000);
    send_request(FUNC_NOTE_OFF, 24'h000000);

    // short ramps: full envelope, off while releasing, restart while releasing
    drain();
    write_regs(24'd2, 24'd2, 24'd16384, 24'd3);
    send_request(FUNC_NOTE_ON, 24'hFFFFFF);
    send_request(FUNC_TICK, 24'hFFFFFF);
    send_request(FUNC_TICK, 24'h7FFFFF);
    send_request(FUNC_TICK, 24'hFFFFFF);
    send_request(FUNC_TICK, 24'h800000);
    send_request(FUNC_TICK, 24'h123457);
    send_request(FUNC_NOTE_OFF, 24'h000000);
    send_request(FUNC_TICK, 24'hFFFFFF);
    send_request(FUNC_NOTE_OFF, 24'h000000);
    send_request(FUNC_NOTE_ON, 24'h000000);
    send_request(FUNC_TICK, 24'h7FFFFF);
    send_request(FUNC_NOTE_OFF, 24'h000000);
    send_request(FUNC_TICK, 24'hFFFFFF);
    send_request(FUNC_TICK, 24'h800001);
    send_request(FUNC_TICK, 24'h400000);

    // random phrases, settings change between phases while a note may still sound
    phase_no = 0;
    while (sent < RUN_ITEMS) begin
      drain();
      case (phase_no)
        0: write_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'hFFFFFF);
        1: write_regs(24'h000000, 24'h000000, 24'(UNITY), 24'h000000);
        2: write_regs(24'd1, 24'd1, 24'h5AFFFF, 24'd1);
        default: write_regs(pick_len(), pick_len(), pick_level(), pick_len());
      endcase
      steady = (phase_no == 1);
      if (phase_no == 2) holds_asked++;
      repeat ($urandom_range(3, 8)) begin
        if (sent < RUN_ITEMS) play_phrase();
      end
      phase_no++;
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
